// ===== hw/rtl/twtm_pkg.sv =====
// ----------------------------------------------------------------------------
// twtm_pkg: shared types and constants of the timing wheel timer manager
// Transfer structs of both channels, operation codes and the divider width.
// ----------------------------------------------------------------------------
package twtm_pkg;

    // action codes of the input channel
    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // kind codes of the output channel
    localparam logic [1:0] KIND_SET_ACK    = 2'd0;
    localparam logic [1:0] KIND_EXPIRY     = 2'd1;
    localparam logic [1:0] KIND_REMOVE_ACK = 2'd2;
    localparam logic [1:0] KIND_TICK_DONE  = 2'd3;

    // divider operand: non-negative timeout
    localparam int DIVIDEND_W = 31;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] timeout;
        logic               has_callback;
        logic [31:0]        cookie;
        logic [3:0]         handle;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [3:0]  result_handle;
        logic [31:0] result_cookie;
        logic        last;
    } t_out;

    // per-cell control: load takes the shared load bus, shift takes the neighbour
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/twtm_cell.sv =====
// ----------------------------------------------------------------------------
// twtm_cell: one timer entry of the ordered entry chain
// Holds one entry, loads a new one, takes its neighbour's entry on a shift,
// and flags a handle match for removal.
// ----------------------------------------------------------------------------
module twtm_cell #(
    parameter int EW = 64,
    parameter int HW = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  twtm_pkg::t_cell_ctrl   i_ctrl,
    input  logic [EW-1:0]          i_load_entry,
    input  logic [EW-1:0]          i_next_entry,
    input  logic [HW-1:0]          i_cmp_handle,
    output logic [EW-1:0]          o_entry,
    output logic                   o_hit
);

    logic [EW-1:0] r_entry;

    // payload only: validity lives in the fill count of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= r_entry;
        end else if (i_ctrl.load) begin
            r_entry <= i_load_entry;
        end else if (i_ctrl.shift) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = (r_entry[EW-1 -: HW] == i_cmp_handle);

endmodule

// ===== hw/rtl/twtm_div.sv =====
// ----------------------------------------------------------------------------
// twtm_div: divider by one of two fixed divisors
// Reciprocal multiplication gives the quotient at the start edge; the
// remainder is registered at the next edge and is valid with the done pulse.
// ----------------------------------------------------------------------------
module twtm_div #(
    parameter int DIV_A = 1,
    parameter int DIV_B = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_sel,
    input  logic [twtm_pkg::DIVIDEND_W-1:0]     i_dividend,
    output logic                                o_done,
    output logic [twtm_pkg::DIVIDEND_W-1:0]     o_quot,
    output logic [twtm_pkg::DIVIDEND_W-1:0]     o_rem
);

    localparam int QW = twtm_pkg::DIVIDEND_W;
    localparam int PW = 2 * QW + 1;

    // shift = QW + ceil(log2 d), factor = ceil(2^shift / d): exact for any QW-bit dividend
    localparam int SH_A = QW + $clog2(DIV_A);
    localparam int SH_B = QW + $clog2(DIV_B);
    localparam logic [63:0] MUL_A64 =
        ((64'd1 << SH_A) + 64'(DIV_A) - 64'd1) / 64'(DIV_A);
    localparam logic [63:0] MUL_B64 =
        ((64'd1 << SH_B) + 64'(DIV_B) - 64'd1) / 64'(DIV_B);
    localparam logic [QW:0] MUL_A = (QW + 1)'(MUL_A64);
    localparam logic [QW:0] MUL_B = (QW + 1)'(MUL_B64);

    logic          r_busy;
    logic          r_done;
    logic          r_sel;
    logic [QW-1:0] r_x;
    logic [QW-1:0] r_q;
    logic [QW-1:0] r_rem;

    logic [QW:0]   mul;
    logic [PW-1:0] prod;
    logic [QW-1:0] quot;
    logic [QW-1:0] back;

    always_comb begin
        mul  = i_sel ? MUL_B : MUL_A;
        prod = PW'(i_dividend) * PW'(mul);
        quot = i_sel ? QW'(prod >> SH_B) : QW'(prod >> SH_A);
        // quotient times divisor, modulo 2^QW: the remainder is far below that
        back = r_sel ? QW'(r_q * QW'(DIV_B)) : QW'(r_q * QW'(DIV_A));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
            if (i_start) begin
                r_sel <= i_sel;
                r_x   <= i_dividend;
                r_q   <= quot;
            end
            if (r_busy) begin
                r_rem <= r_x - back;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/timing_wheel_timer_manager_unit.sv =====
// Remove: the ack is registered straight from the idle state. Set with a valid
// timeout: two reciprocal divisions (timeout/TICK_UNIT, then ticks/SLOTS), then the ack.
// Tick: every occupied entry is turned through the head of the entry chain,
// then the done result follows. One item at a time. Output stalls hold the work.
// Negative timeout, full pool: refused set ack from idle; action three: no result.
// Reset (synchronous, active low): pool empty, slot pointer zero, no result pending.
// ----------------------------------------------------------------------------
// timing_wheel_timer_manager_unit: single-level hashed timing wheel
// A chain of entry cells kept in insertion order; ticks rotate the chain
// through its head, expiring or ageing entries of the current slot.
// ----------------------------------------------------------------------------
module timing_wheel_timer_manager_unit #(
    parameter int SLOTS     = 64,
    parameter int TICK_UNIT = 1,
    parameter int POOL_SIZE = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  twtm_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output twtm_pkg::t_out   o_out_data
);

    // widths that follow from the parameters
    localparam int HW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam int SW = $clog2(SLOTS);
    localparam int RW = 32 - $clog2(SLOTS + 1);
    localparam int QW = twtm_pkg::DIVIDEND_W;

    typedef struct packed {
        logic [HW-1:0] handle;
        logic [SW-1:0] slot;
        logic [RW-1:0] rounds;
        logic [31:0]   cookie;
        logic          notify;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_TICK,
        S_DIV_SLOT,
        S_SET,
        S_TICK,
        S_TDONE
    } t_state;

    // control state
    t_state          r_state;
    logic [CW-1:0]   r_count;     // occupied cells, oldest at cell zero
    logic [CW-1:0]   r_iter;      // entries still to visit in this tick
    logic [POOL_SIZE-1:0] r_valid;
    logic [SW-1:0]   r_cur;
    logic            r_out_valid;
    twtm_pkg::t_out  r_out;

    // pending set
    logic [HW-1:0]   r_new_handle;
    logic [31:0]     r_new_cookie;
    logic            r_new_notify;
    logic [RW-1:0]   r_new_rounds;
    logic [SW-1:0]   r_new_slot;

    // chain
    logic [EW-1:0]          cell_q   [POOL_SIZE];
    logic [EW-1:0]          cell_nxt [POOL_SIZE];
    logic [POOL_SIZE-1:0]   cell_hit;
    twtm_pkg::t_cell_ctrl   cell_ctrl [POOL_SIZE];
    logic [EW-1:0]          load_bus;

    // divider
    logic            div_start;
    logic            div_sel;
    logic [QW-1:0]   div_dividend;
    logic            div_done;
    logic [QW-1:0]   div_quot;
    logic [QW-1:0]   div_rem;

    // combinational control
    logic            can_emit;
    logic            acc;
    logic            free_found;
    logic [HW-1:0]   free_idx;
    logic [HW-1:0]   h_idx;
    logic            rem_ok;
    logic            do_remove;
    logic            do_commit;
    logic            do_step;
    logic            step_expire;
    logic            step_in_slot;
    t_entry          head;
    t_entry          head_kept;
    t_entry          new_entry;
    logic [SW:0]     slot_sum;
    logic [SW-1:0]   slot_wrapped;

    assign can_emit = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && can_emit;
    assign acc = i_in_valid && o_in_ready;

    // lowest free entry
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = POOL_SIZE - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = HW'(i);
            end
        end
    end

    assign h_idx     = HW'(i_in_data.handle);
    assign rem_ok    = (32'(i_in_data.handle) < POOL_SIZE) && r_valid[h_idx];
    assign do_remove = acc && (i_in_data.action == twtm_pkg::ACT_REMOVE) && rem_ok;
    assign do_commit = (r_state == S_SET) && can_emit;
    assign do_step   = (r_state == S_TICK) && can_emit;

    // head of the chain during a tick: expire it, or age it if in the current slot, and send it to the back
    always_comb begin
        head         = t_entry'(cell_q[0]);
        step_in_slot = (head.slot == r_cur);
        step_expire  = step_in_slot && (head.rounds == '0);
        head_kept    = head;
        if (step_in_slot) begin
            head_kept.rounds = head.rounds - 1'b1;
        end
    end

    // (current + ticks) mod SLOTS from the remainder of ticks/SLOTS
    always_comb begin
        slot_sum = {1'b0, r_cur} + {1'b0, SW'(div_rem)};
        if (slot_sum >= (SW + 1)'(SLOTS)) begin
            slot_wrapped = SW'(slot_sum - (SW + 1)'(SLOTS));
        end else begin
            slot_wrapped = SW'(slot_sum);
        end
    end

    always_comb begin
        new_entry.handle = r_new_handle;
        new_entry.slot   = r_new_slot;
        new_entry.rounds = r_new_rounds;
        new_entry.cookie = r_new_cookie;
        new_entry.notify = r_new_notify;
        load_bus = do_commit ? EW'(new_entry) : EW'(head_kept);
    end

    // per-cell control: append, rotate, or close the gap left by a removal
    always_comb begin
        logic gap;
        gap = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            cell_ctrl[i].load  = 1'b0;
            cell_ctrl[i].shift = 1'b0;
            gap = gap || (do_remove && cell_hit[i] && (CW'(i) < r_count));
            if (do_commit) begin
                cell_ctrl[i].load = (CW'(i) == r_count);
            end else if (do_step) begin
                if (step_expire) begin
                    cell_ctrl[i].shift = 1'b1;
                end else begin
                    cell_ctrl[i].load  = (CW'(i) == r_count - 1'b1);
                    cell_ctrl[i].shift = (CW'(i) < r_count - 1'b1);
                end
            end else begin
                cell_ctrl[i].shift = gap;
            end
        end
    end

    // divider hand-off: timeout by tick unit, then ticks by slot count
    always_comb begin
        div_start    = 1'b0;
        div_sel      = 1'b0;
        div_dividend = i_in_data.timeout[QW-1:0];
        if (acc && (i_in_data.action == twtm_pkg::ACT_SET) && !i_in_data.timeout[31]
            && free_found) begin
            div_start = 1'b1;
        end else if ((r_state == S_DIV_TICK) && div_done) begin
            div_start    = 1'b1;
            div_sel      = 1'b1;
            div_dividend = div_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_iter      <= '0;
            r_valid     <= '0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        unique case (i_in_data.action)
                            twtm_pkg::ACT_SET: begin
                                if (i_in_data.timeout[31] || !free_found) begin
                                    // rejected timeout or full pool
                                    r_out_valid         <= 1'b1;
                                    r_out.kind          <= twtm_pkg::KIND_SET_ACK;
                                    r_out.ok            <= 1'b0;
                                    r_out.result_handle <= '0;
                                    r_out.result_cookie <= '0;
                                    r_out.last          <= 1'b1;
                                end else begin
                                    r_new_handle <= free_idx;
                                    r_new_cookie <= i_in_data.cookie;
                                    r_new_notify <= i_in_data.has_callback;
                                    r_state      <= S_DIV_TICK;
                                end
                            end
                            twtm_pkg::ACT_REMOVE: begin
                                if (rem_ok) begin
                                    r_valid[h_idx] <= 1'b0;
                                    r_count        <= r_count - 1'b1;
                                end
                                r_out_valid         <= 1'b1;
                                r_out.kind          <= twtm_pkg::KIND_REMOVE_ACK;
                                r_out.ok            <= rem_ok;
                                r_out.result_handle <= i_in_data.handle;
                                r_out.result_cookie <= '0;
                                r_out.last          <= 1'b1;
                            end
                            twtm_pkg::ACT_TICK: begin
                                r_iter  <= r_count;
                                r_state <= (r_count == '0) ? S_TDONE : S_TICK;
                            end
                            default: begin
                                // unused action: drop silently
                            end
                        endcase
                    end
                end
                S_DIV_TICK: begin
                    if (div_done) begin
                        r_state <= S_DIV_SLOT;
                    end
                end
                S_DIV_SLOT: begin
                    if (div_done) begin
                        r_new_rounds <= RW'(div_quot);
                        r_new_slot   <= slot_wrapped;
                        r_state      <= S_SET;
                    end
                end
                S_SET: begin
                    if (can_emit) begin
                        r_valid[r_new_handle] <= 1'b1;
                        r_count               <= r_count + 1'b1;
                        r_out_valid           <= 1'b1;
                        r_out.kind            <= twtm_pkg::KIND_SET_ACK;
                        r_out.ok              <= 1'b1;
                        r_out.result_handle   <= 4'(r_new_handle);
                        r_out.result_cookie   <= '0;
                        r_out.last            <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                S_TICK: begin
                    if (can_emit) begin
                        if (step_expire) begin
                            r_valid[head.handle] <= 1'b0;
                            r_count              <= r_count - 1'b1;
                            if (head.notify) begin
                                r_out_valid         <= 1'b1;
                                r_out.kind          <= twtm_pkg::KIND_EXPIRY;
                                r_out.ok            <= 1'b1;
                                r_out.result_handle <= 4'(head.handle);
                                r_out.result_cookie <= head.cookie;
                                r_out.last          <= 1'b0;
                            end
                        end
                        r_iter <= r_iter - 1'b1;
                        if (r_iter == CW'(1)) begin
                            r_state <= S_TDONE;
                        end
                    end
                end
                S_TDONE: begin
                    if (can_emit) begin
                        r_out_valid         <= 1'b1;
                        r_out.kind          <= twtm_pkg::KIND_TICK_DONE;
                        r_out.ok            <= 1'b1;
                        r_out.result_handle <= '0;
                        r_out.result_cookie <= '0;
                        r_out.last          <= 1'b1;
                        // advance the slot pointer
                        r_cur   <= (r_cur == SW'(SLOTS - 1)) ? '0 : r_cur + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // entry chain, oldest entry at cell zero
    for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
        if (g < POOL_SIZE - 1) begin : g_mid
            assign cell_nxt[g] = cell_q[g + 1];
        end else begin : g_end
            assign cell_nxt[g] = '0;
        end
        twtm_cell #(
            .EW (EW),
            .HW (HW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl[g]),
            .i_load_entry (load_bus),
            .i_next_entry (cell_nxt[g]),
            .i_cmp_handle (h_idx),
            .o_entry      (cell_q[g]),
            .o_hit        (cell_hit[g])
        );
    end

    twtm_div #(
        .DIV_A (TICK_UNIT),
        .DIV_B (SLOTS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_sel      (div_sel),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the timing wheel timer manager
// Drives set, remove and tick requests over the input channel with random
// gaps and back-pressure. A scoreboard keeps its own copy of the timer pool
// and the wheel, works out the acks, expiry events and tick-done results
// each request must cause, and compares every transfer on the output channel
// field by field, in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int WHEEL_SLOTS = 64;
    localparam int TICK_UNIT   = 1;
    localparam int POOL_SIZE   = 16;
    localparam int RANDOM_REQS = 130;
    localparam int DRAIN_CYCLES = 40;

    // the fourth action code has no name in the package; the block ignores it
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow timer pool, wheel pointer and the queue of results
    // still owed by the block.
    // ------------------------------------------------------------------------
    class timer_pool_tracker;
        bit          live      [POOL_SIZE];
        bit [5:0]    slot_of   [POOL_SIZE];
        bit [31:0]   rounds_of [POOL_SIZE];
        bit [31:0]   cookie_of [POOL_SIZE];
        bit          notify_of [POOL_SIZE];
        bit [31:0]   stamp_of  [POOL_SIZE];
        bit [5:0]    wheel_pos;
        bit [31:0]   set_count;
        twtm_pkg::t_out owed[$];
        twtm_pkg::t_out batch[$];
        int          failures;

        function void emit(logic [1:0] kind, bit ok, bit [3:0] h, bit [31:0] ck);
            twtm_pkg::t_out r;
            r.kind          = kind;
            r.ok            = ok;
            r.result_handle = h;
            r.result_cookie = ck;
            r.last          = 1'b0;
            batch.insert(batch.size(), r);
        endfunction

        function bit [31:0] age_of(int e);
            return set_count - stamp_of[e];
        endfunction

        // Return a random entry that is currently in use, if any.
        function bit pick_live(output bit [3:0] h);
            int cands[$];
            for (int i = 0; i < POOL_SIZE; i++)
                if (live[i]) cands.insert(cands.size(), i);
            if (cands.size() == 0) return 1'b0;
            h = 4'(cands[$urandom_range(0, cands.size() - 1)]);
            return 1'b1;
        endfunction

        // Note an accepted request and queue the results it must cause.
        function void take_request(twtm_pkg::t_in req);
            bit [31:0] ticks;
            int        idx;
            int        j;
            int        order[$];
            batch.delete();
            case (req.action)
                twtm_pkg::ACT_SET: begin
                    idx = -1;
                    for (int i = 0; i < POOL_SIZE; i++)
                        if (!live[i] && idx < 0) idx = i;
                    if (req.timeout[31] || idx < 0) begin
                        emit(twtm_pkg::KIND_SET_ACK, 1'b0, 4'd0, 32'd0);
                    end else begin
                        ticks          = req.timeout;
                        ticks          = ticks / TICK_UNIT;
                        live[idx]      = 1'b1;
                        rounds_of[idx] = ticks / WHEEL_SLOTS;
                        slot_of[idx]   = 6'((wheel_pos + ticks % WHEEL_SLOTS) % WHEEL_SLOTS);
                        cookie_of[idx] = req.cookie;
                        notify_of[idx] = req.has_callback;
                        stamp_of[idx]  = set_count;
                        set_count      = set_count + 1;
                        emit(twtm_pkg::KIND_SET_ACK, 1'b1, idx[3:0], 32'd0);
                    end
                end
                twtm_pkg::ACT_REMOVE: begin
                    if (req.handle < POOL_SIZE && live[req.handle]) begin
                        live[req.handle] = 1'b0;
                        emit(twtm_pkg::KIND_REMOVE_ACK, 1'b1, req.handle, 32'd0);
                    end else begin
                        emit(twtm_pkg::KIND_REMOVE_ACK, 1'b0, req.handle, 32'd0);
                    end
                end
                twtm_pkg::ACT_TICK: begin
                    // order the entries of this slot oldest first
                    for (int i = 0; i < POOL_SIZE; i++) begin
                        if (live[i] && slot_of[i] == wheel_pos) begin
                            j = 0;
                            while (j < order.size() && age_of(order[j]) >= age_of(i)) j++;
                            order.insert(j, i);
                        end
                    end
                    foreach (order[k]) begin
                        if (rounds_of[order[k]] == 0) begin
                            live[order[k]] = 1'b0;
                            if (notify_of[order[k]])
                                emit(twtm_pkg::KIND_EXPIRY, 1'b1, order[k][3:0],
                                     cookie_of[order[k]]);
                        end else begin
                            rounds_of[order[k]] = rounds_of[order[k]] - 1;
                        end
                    end
                    emit(twtm_pkg::KIND_TICK_DONE, 1'b1, 4'd0, 32'd0);
                    wheel_pos = 6'((wheel_pos + 1) % WHEEL_SLOTS);
                end
                default: ;
            endcase
            if (batch.size() > 0) begin
                batch[batch.size() - 1].last = 1'b1;
                foreach (batch[k]) owed.insert(owed.size(), batch[k]);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        // Check one output transfer against the oldest owed result.
        function void match_result(twtm_pkg::t_out got);
            twtm_pkg::t_out want;
            if (owed.size() == 0) begin
                $error("result with nothing owed: %p", got);
                failures++;
                return;
            end
            want = owed.pop_front();
            compare_field("kind",          32'(want.kind),          32'(got.kind));
            compare_field("ok",            32'(want.ok),            32'(got.ok));
            compare_field("result_handle", 32'(want.result_handle), 32'(got.result_handle));
            compare_field("result_cookie", want.result_cookie,      got.result_cookie);
            compare_field("last",          32'(want.last),          32'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    twtm_pkg::t_in  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    twtm_pkg::t_out out_data;

    timer_pool_tracker tracker;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    timing_wheel_timer_manager_unit #(
        .SLOTS     (WHEEL_SLOTS),
        .TICK_UNIT (TICK_UNIT),
        .POOL_SIZE (POOL_SIZE)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // Request builders: fields a request does not use carry random noise so
    // that every input bit toggles.
    // ------------------------------------------------------------------------
    function automatic twtm_pkg::t_in noise_req(logic [1:0] act);
        twtm_pkg::t_in r;
        r.action       = act;
        r.timeout      = $urandom;
        r.has_callback = 1'($urandom_range(0, 1));
        r.cookie       = $urandom;
        r.handle       = 4'($urandom_range(0, 15));
        return r;
    endfunction

    function automatic twtm_pkg::t_in set_req(logic [31:0] tmo, bit cb, logic [31:0] ck);
        twtm_pkg::t_in r;
        r              = noise_req(twtm_pkg::ACT_SET);
        r.timeout      = tmo;
        r.has_callback = cb;
        r.cookie       = ck;
        return r;
    endfunction

    function automatic twtm_pkg::t_in remove_req(logic [3:0] h);
        twtm_pkg::t_in r;
        r        = noise_req(twtm_pkg::ACT_REMOVE);
        r.handle = h;
        return r;
    endfunction

    // Mostly short timeouts so that timers really expire within the run;
    // now and then a full-range value (negative ones included) or an exact
    // multiple of the wheel size. Removes mostly target a live entry.
    function automatic twtm_pkg::t_in random_req();
        int        pick;
        int        shape;
        bit [3:0]  h;
        logic [31:0] tmo;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            shape = $urandom_range(0, 99);
            if (shape < 75)      tmo = $urandom_range(0, 40);
            else if (shape < 85) tmo = $urandom_range(0, 200);
            else if (shape < 95) tmo = $urandom;
            else                 tmo = WHEEL_SLOTS * $urandom_range(0, 3);
            return set_req(tmo, $urandom_range(0, 3) != 0, $urandom);
        end
        if (pick < 63) begin
            if ($urandom_range(0, 3) != 0 && tracker.pick_live(h))
                return remove_req(h);
            return remove_req(4'($urandom_range(0, 15)));
        end
        if (pick < 96)
            return noise_req(twtm_pkg::ACT_TICK);
        return noise_req(ACT_UNUSED);
    endfunction

    // ------------------------------------------------------------------------
    // Input driver. Call again in the step of the transfer: that step either
    // drops valid for a gap or presents the next request straight away.
    // ------------------------------------------------------------------------
    task automatic send_req(twtm_pkg::t_in req);
        int gap;
        gap = $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        tracker.take_request(req);
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall at random before each result.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = $urandom_range(0, 17);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            tracker.match_result(out_data);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int counted;
        twtm_pkg::t_in req;
        tracker = new();
        counted = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero and largest timeouts, both negative extremes,
        // notify on and off, cookie extremes, one timer a full lap away.
        send_req(set_req(32'd0, 1'b1, 32'hFFFF_FFFF));
        send_req(set_req(32'hFFFF_FFFF, 1'b1, 32'h1234_5678));
        send_req(set_req(32'h8000_0000, 1'b0, 32'h0));
        send_req(set_req(32'h7FFF_FFFF, 1'b0, 32'h0));
        send_req(set_req(32'(WHEEL_SLOTS), 1'b1, 32'hA5A5_5A5A));
        send_req(set_req(32'd0, 1'b0, 32'h5A5A_A5A5));
        // slot zero: one event, one silent expiry, one timer loses a round
        send_req(noise_req(twtm_pkg::ACT_TICK));
        // free a live handle, then the same one again, then a never-used one
        send_req(remove_req(4'd1));
        send_req(remove_req(4'd1));
        send_req(remove_req(4'd15));
        send_req(noise_req(ACT_UNUSED));
        // fill the pool, then one set more must be refused
        for (int i = 0; i < POOL_SIZE; i++)
            send_req(set_req(32'(i * 3), 1'(i % 2), $urandom));

        // Random requests; ignored ones do not count.
        while (counted < RANDOM_REQS) begin
            req = random_req();
            send_req(req);
            if (req.action != ACT_UNUSED) counted++;
        end
        in_valid <= 1'b0;

        // drain, then keep watching the output for stray results
        while (tracker.owed.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0 && tracker.owed.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
